[src/bsh32_pkg.sv]
// Shared types, constants and mixing functions for the byte stream hash.
`default_nettype none

package bsh32_pkg;

    // Command queue between the byte front end and the hash back end
    localparam int CMD_DEPTH = 2;                 // power of two
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // Number of bytes held while a group of four is gathered
    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_ONE   = 2'd1,
        PH_TWO   = 2'd2,
        PH_THREE = 2'd3
    } t_phase;

    // One command word from the front end to the back end
    typedef struct packed {
        logic        seed_vld;   // load hash with message length
        logic [31:0] seed;
        logic        rnd_vld;    // run one full four-byte round
        logic [15:0] rnd_lo;
        logic [15:0] rnd_hi;
        logic        fin_vld;    // mix tail, avalanche, emit
        logic        fin_empty;  // empty message: emit zero
        t_phase      tail_phase;
        logic [23:0] tail_held;
    } t_cmd;

    // Sign-extend a byte to 32 bits
    function automatic logic [31:0] f_sext8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    // One full mixing round on two 16-bit halves
    function automatic logic [31:0] f_full_round(input logic [31:0] h_in,
                                                 input logic [15:0] lo,
                                                 input logic [15:0] hi);
        logic [31:0] h;
        logic [31:0] t;
        h = h_in + {16'd0, lo};
        t = ({16'd0, hi} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    // Tail of one to three bytes
    function automatic logic [31:0] f_tail(input logic [31:0] h_in,
                                           input t_phase      ph,
                                           input logic [23:0] held);
        logic [31:0] h;
        h = h_in;
        unique case (ph)
            PH_THREE: begin
                h = h + {16'd0, held[15:0]};
                h = h ^ (h << 16);
                h = h ^ (f_sext8(held[23:16]) << 18);
                h = h + (h >> 11);
            end
            PH_TWO: begin
                h = h + {16'd0, held[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            PH_ONE: begin
                h = h + f_sext8(held[7:0]);
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: begin
                h = h_in;
            end
        endcase
        return h;
    endfunction

    // Avalanche, first three steps
    function automatic logic [31:0] f_aval_a(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in ^ (h_in << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        return h;
    endfunction

    // Avalanche, last three steps
    function automatic logic [31:0] f_aval_b(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in + (h_in >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

endpackage

`default_nettype wire

[src/bsh32_if.sv]
// Handshake channels for message bytes in and hash words out.
`default_nettype none

interface bsh32_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first;
    logic        last;
    logic [31:0] message_length;

    modport source (output valid, output data_byte, output first, output last,
                    output message_length, input ready);
    modport sink   (input valid, input data_byte, input first, input last,
                    input message_length, output ready);
endinterface

interface bsh32_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

[src/byte_stream_hash_32.sv]
// Top level of the streaming 32-bit byte hash.
`default_nettype none

// Takes one message byte per word and returns one 32-bit hash word per
// message, after the word marked last. Bytes are accepted at one per cycle
// while the command queue is not full. The front end gathers bytes into
// groups of four and issues a command only on a first, a full group or a
// last byte; a two-entry command queue separates it from the back end,
// which keeps the running hash, runs each round as its command is taken and
// finishes the tail and avalanche in a three-stage pipeline into a registered
// output. A message that begins without a first marker right after a last
// byte continues from the emitted hash and so waits until the pipeline has
// written it back, which takes longer while the output is held off.
module byte_stream_hash_32
    import bsh32_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bsh32_in_if.sink    i_in,
    bsh32_out_if.source o_out
);

    logic cmd_push;
    t_cmd cmd_in;
    logic cmd_full;
    logic cmd_valid;
    t_cmd cmd_out;
    logic cmd_pop;

    bsh32_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    bsh32_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_out)
    );

    bsh32_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

[src/bsh32_front.sv]
// Front end: gathers bytes into groups and issues hash commands.
`default_nettype none

module bsh32_front
    import bsh32_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bsh32_in_if.sink    i_in,
    input  wire logic   i_cmd_full,
    output logic        o_cmd_push,
    output t_cmd        o_cmd
);

    logic [23:0] r_held, n_held;
    t_phase      r_phase, n_phase;
    logic        r_empty, n_empty;

    logic        accept;
    logic [23:0] base_held;
    t_phase      base_phase;
    logic        base_empty;
    logic [23:0] grp_held;
    t_phase      grp_phase;
    logic        rnd;

    assign i_in.ready = !i_cmd_full;
    assign accept     = i_in.valid && i_in.ready;

    // Byte gathering and round detection
    always_comb begin
        base_held  = i_in.first ? 24'd0 : r_held;
        base_phase = i_in.first ? PH_NONE : r_phase;
        base_empty = i_in.first ? (i_in.message_length == 32'd0) : r_empty;
        grp_held   = base_held;
        grp_phase  = base_phase;
        rnd        = 1'b0;
        if (!base_empty) begin
            unique case (base_phase)
                PH_NONE: begin
                    grp_held  = {base_held[23:8], i_in.data_byte};
                    grp_phase = PH_ONE;
                end
                PH_ONE: begin
                    grp_held  = {base_held[23:16], i_in.data_byte, base_held[7:0]};
                    grp_phase = PH_TWO;
                end
                PH_TWO: begin
                    grp_held  = {i_in.data_byte, base_held[15:0]};
                    grp_phase = PH_THREE;
                end
                PH_THREE: begin
                    grp_held  = 24'd0;
                    grp_phase = PH_NONE;
                    rnd       = 1'b1;
                end
                default: begin
                    grp_held  = base_held;
                    grp_phase = base_phase;
                end
            endcase
        end
    end

    // Command word
    always_comb begin
        o_cmd.seed_vld   = i_in.first;
        o_cmd.seed       = i_in.message_length;
        o_cmd.rnd_vld    = rnd;
        o_cmd.rnd_lo     = base_held[15:0];
        o_cmd.rnd_hi     = {i_in.data_byte, base_held[23:16]};
        o_cmd.fin_vld    = i_in.last;
        o_cmd.fin_empty  = base_empty;
        o_cmd.tail_phase = grp_phase;
        o_cmd.tail_held  = grp_held;
        o_cmd_push       = accept && (i_in.first || rnd || i_in.last);
    end

    // Next gathering state; a last word clears it
    always_comb begin
        n_held  = r_held;
        n_phase = r_phase;
        n_empty = r_empty;
        if (accept) begin
            if (i_in.last) begin
                n_held  = 24'd0;
                n_phase = PH_NONE;
                n_empty = 1'b0;
            end else begin
                n_held  = grp_held;
                n_phase = grp_phase;
                n_empty = base_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 24'd0;
            r_phase <= PH_NONE;
            r_empty <= 1'b0;
        end else begin
            r_held  <= n_held;
            r_phase <= n_phase;
            r_empty <= n_empty;
        end
    end

endmodule

`default_nettype wire

[src/bsh32_cmd_fifo.sv]
// Short command queue between front end and back end.
`default_nettype none

module bsh32_cmd_fifo
    import bsh32_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wptr;
    logic [CMD_PTR_W-1:0] r_rptr;
    logic [CMD_CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CMD_CNT_W'(CMD_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + CMD_PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + CMD_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CMD_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CMD_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[src/bsh32_back.sv]
// Back end: running hash, tail and avalanche pipeline, output register.
`default_nettype none

module bsh32_back
    import bsh32_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    bsh32_out_if.source o_out
);

    // One finishing message in flight
    typedef struct packed {
        logic        vld;
        logic        wb;      // result becomes the running hash
        logic        empty;
        t_phase      phase;
        logic [23:0] held;
        logic [31:0] h;
    } t_fin;

    logic [31:0] r_hash;
    t_fin        r_s1, r_s2, r_s3;
    logic        r_out_vld;
    logic [31:0] r_out_hash;

    logic        adv;
    logic        pend;
    logic        go;
    logic        reseed;
    logic [31:0] h0;
    logic [31:0] h1;
    logic [31:0] fin_hash;

    // Whole pipeline moves when the output slot frees up
    assign adv    = !r_out_vld || o_out.ready;
    assign pend   = (r_s1.vld && r_s1.wb) || (r_s2.vld && r_s2.wb) ||
                    (r_s3.vld && r_s3.wb);
    assign go     = i_cmd_valid && adv && (i_cmd.seed_vld || !pend);
    assign reseed = go && i_cmd.seed_vld;

    assign o_cmd_pop        = go;
    assign o_out.valid      = r_out_vld;
    assign o_out.hash_value = r_out_hash;

    // Seed and full round
    always_comb begin
        h0 = i_cmd.seed_vld ? i_cmd.seed : r_hash;
        h1 = i_cmd.rnd_vld ? f_full_round(h0, i_cmd.rnd_lo, i_cmd.rnd_hi) : h0;
        fin_hash = r_s3.empty ? 32'd0 : f_aval_b(r_s3.h);
    end

    // Running hash: command update wins over a late finish write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= 32'd0;
        end else if (go) begin
            r_hash <= h1;
        end else if (adv && r_s3.vld && r_s3.wb) begin
            r_hash <= fin_hash;
        end
    end

    // Finishing pipeline: flags are reset, data moves along with them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld  <= 1'b0;
            r_s1.wb   <= 1'b0;
            r_s2.vld  <= 1'b0;
            r_s2.wb   <= 1'b0;
            r_s3.vld  <= 1'b0;
            r_s3.wb   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_s1.vld   <= go && i_cmd.fin_vld;
            r_s1.wb    <= 1'b1;
            r_s2.vld   <= r_s1.vld;
            r_s2.wb    <= r_s1.wb && !reseed;
            r_s3.vld   <= r_s2.vld;
            r_s3.wb    <= r_s2.wb && !reseed;
            r_out_vld  <= r_s3.vld;
            r_s1.empty <= i_cmd.fin_empty;
            r_s1.phase <= i_cmd.tail_phase;
            r_s1.held  <= i_cmd.tail_held;
            r_s1.h     <= h1;
            r_s2.empty <= r_s1.empty;
            r_s2.phase <= r_s1.phase;
            r_s2.held  <= r_s1.held;
            r_s2.h     <= f_tail(r_s1.h, r_s1.phase, r_s1.held);
            r_s3.empty <= r_s2.empty;
            r_s3.phase <= r_s2.phase;
            r_s3.held  <= r_s2.held;
            r_s3.h     <= f_aval_a(r_s2.h);
            r_out_hash <= fin_hash;
        end
    end

endmodule

`default_nettype wire
